[src/spe_pkg.sv]
// ----------------------------------------------------------------------------
// spe_pkg: shared types and constants of the servo PWM edge scheduler
// Field widths, register reset values, register indexes and the table port
// control word.
// ----------------------------------------------------------------------------
package spe_pkg;

	// payload field widths
	localparam int CH_W      = 5;
	localparam int WIDTH_W   = 15;
	localparam int EIDX_W    = 5;
	localparam int CMP_W     = 16;
	localparam int PIN_W     = 32;

	// configuration registers
	localparam int DELAY_W   = 8;
	localparam int TPU_W     = 18;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 18;

	localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_DELAY = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_US  = CFG_IDX_W'(1);

	localparam logic [DELAY_W-1:0] DELAY_RST = DELAY_W'(17);
	localparam logic [TPU_W-1:0]   TPU_RST   = TPU_W'(120796);

	// table reset edge
	localparam logic [WIDTH_W-1:0] RESET_WIDTH = WIDTH_W'(1500);

	// compare arithmetic: width times Q2.16 rate
	localparam int FRAC_W = 16;
	localparam int PROD_W = WIDTH_W + TPU_W;
	localparam int TICK_W = PROD_W - FRAC_W;

	localparam int CHANNELS_DEF = 32;

	// table port control
	typedef struct packed {
		logic rd_en;   // read entry of the current bank
		logic wr_en;   // write one entry
		logic wr_cur;  // write into the current bank, else the other one
		logic swap;    // make the other bank current
	} tbl_ctrl_t;

endpackage

[src/spe_table.sv]
// ----------------------------------------------------------------------------
// spe_table: double-banked edge table
// Two banks of width and mask entries in one memory. Updates read the current
// bank and rebuild the table into the other, then swap. Read data registered.
// ----------------------------------------------------------------------------
module spe_table
	import spe_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tbl_ctrl_t                     ctrl,
	input  logic [$clog2(CHANNELS)-1:0]   rd_addr,
	input  logic [$clog2(CHANNELS)-1:0]   wr_addr,
	input  logic [WIDTH_W-1:0]            wr_width,
	input  logic [CHANNELS-1:0]           wr_mask,
	output logic [WIDTH_W-1:0]            rd_width,
	output logic [CHANNELS-1:0]           rd_mask
);

	localparam int IDX_W = $clog2(CHANNELS);
	localparam int MEM_D = 2 ** (IDX_W + 1);

	logic [WIDTH_W-1:0]  mem_width [MEM_D];
	logic [CHANNELS-1:0] mem_mask  [MEM_D];
	logic                bank_q;
	logic                wr_bank;

	assign wr_bank = ctrl.wr_cur ? bank_q : ~bank_q;

	// flip the current bank after a rebuild
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= 1'b0;
		end else if (ctrl.swap) begin
			bank_q <= ~bank_q;
		end
	end

	// write port
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem_width[{wr_bank, wr_addr}] <= wr_width;
			mem_mask[{wr_bank, wr_addr}]  <= wr_mask;
		end
	end

	// registered read port, held while no read is issued
	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rd_width <= mem_width[{bank_q, rd_addr}];
			rd_mask  <= mem_mask[{bank_q, rd_addr}];
		end
	end

endmodule

[src/spe_compare.sv]
// ----------------------------------------------------------------------------
// spe_compare: edge compare value unit
// Registers width times ticks per microsecond, then drops the fraction,
// subtracts the delay, clamping at zero, and saturates to sixteen bits.
// ----------------------------------------------------------------------------
module spe_compare
	import spe_pkg::*;
(
	input  logic               clk,
	input  logic               en,
	input  logic [WIDTH_W-1:0] width,
	input  logic [TPU_W-1:0]   ticks_per_us_q16,
	input  logic [DELAY_W-1:0] compare_delay,
	output logic [CMP_W-1:0]   compare_time
);

	logic [PROD_W-1:0] prod_q;
	logic [TICK_W-1:0] ticks;
	logic [TICK_W-1:0] delay_ext;
	logic [TICK_W-1:0] diff;

	// multiply stage
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= PROD_W'(width) * PROD_W'(ticks_per_us_q16);
		end
	end

	// subtract and saturate
	assign ticks     = prod_q[PROD_W-1:FRAC_W];
	assign delay_ext = TICK_W'(compare_delay);
	assign diff      = ticks - delay_ext;

	always_comb begin
		if (ticks <= delay_ext) begin
			compare_time = '0;
		end else if (diff > TICK_W'({CMP_W{1'b1}})) begin
			compare_time = {CMP_W{1'b1}};
		end else begin
			compare_time = diff[CMP_W-1:0];
		end
	end

endmodule

[src/servo_pwm_edge_scheduler.sv]
// ----------------------------------------------------------------------------
// servo_pwm_edge_scheduler: sorted edge table for multichannel servo PWM
// Operation: an update walks the old table at one entry a cycle, pausing once
//   for a mid-table insert, and closes with a tail step that appends the new
//   edge if not yet placed and swaps banks; then emits each edge through the
//   table read port and the shared compare multiplier, stalling on out_ready.
// Input: a new item is accepted only after the last word of its schedule
//   is loaded into the output register.
// Reset: one cycle after reset writes the 1500 us edge, in_ready stays low.
// ----------------------------------------------------------------------------
module servo_pwm_edge_scheduler
	import spe_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [CH_W-1:0]      channel,
	input  logic [WIDTH_W-1:0]   width,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [EIDX_W-1:0]    edge_index,
	output logic [CMP_W-1:0]     compare_time,
	output logic [PIN_W-1:0]     pin_pattern,
	output logic                 last
);

	localparam int IDX_W = $clog2(CHANNELS);
	localparam int CNT_W = $clog2(CHANNELS + 1);
	localparam int PAT_W = (CHANNELS > PIN_W) ? CHANNELS : PIN_W;

	typedef enum logic [2:0] {
		S_INIT, S_IDLE, S_MEVAL, S_MWR2, S_MTAIL, S_ERD, S_EMUL, S_EOUT
	} state_t;

	state_t              state_q;
	logic [DELAY_W-1:0]  delay_q;
	logic [TPU_W-1:0]    tpu_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    rd_idx_q;
	logic [CNT_W-1:0]    wr_idx_q;
	logic [CNT_W-1:0]    k_q;
	logic                ins_q;
	logic [WIDTH_W-1:0]  w_q;
	logic [CHANNELS-1:0] bit_q;
	logic [CHANNELS-1:0] pattern_q;
	logic                out_valid_q;
	logic [EIDX_W-1:0]   edge_index_q;
	logic [CMP_W-1:0]    compare_time_q;
	logic [PIN_W-1:0]    pin_pattern_q;
	logic                last_q;

	tbl_ctrl_t           tctl;
	logic [IDX_W-1:0]    t_rd_addr;
	logic [IDX_W-1:0]    t_wr_addr;
	logic [WIDTH_W-1:0]  t_wr_width;
	logic [CHANNELS-1:0] t_wr_mask;
	logic [WIDTH_W-1:0]  rd_width;
	logic [CHANNELS-1:0] rd_mask;
	logic [CMP_W-1:0]    cmp_time;

	logic                in_acc;
	logic                upd;
	logic [CHANNELS-1:0] in_bit;
	logic [CHANNELS-1:0] mask_n;
	logic                hit;
	logic                keep;
	logic                ins_here;
	logic [CNT_W-1:0]    next_rd;
	logic                more;
	logic                is_last;
	logic                out_free;
	logic [PAT_W-1:0]    pattern_ext;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign upd       = (32'(channel) < CHANNELS);
	assign in_bit    = {{(CHANNELS-1){1'b0}}, 1'b1} << channel;

	// merge decisions on the entry just read
	assign mask_n   = rd_mask & ~bit_q;
	assign hit      = (rd_width == w_q);
	assign keep     = (mask_n != '0);
	assign ins_here = !ins_q && !hit && keep && (w_q < rd_width);
	assign next_rd  = rd_idx_q + CNT_W'(1);
	assign more     = (next_rd < cnt_q);

	assign is_last     = ((k_q + CNT_W'(1)) == cnt_q);
	assign out_free    = !out_valid_q || out_ready;
	assign pattern_ext = PAT_W'(pattern_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RST;
			tpu_q   <= TPU_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_COMPARE_DELAY: delay_q <= cfg_data[DELAY_W-1:0];
				CFG_TICKS_PER_US:  tpu_q   <= cfg_data[TPU_W-1:0];
				default: ;
			endcase
		end
	end

	// table port drive
	always_comb begin
		tctl       = '0;
		t_rd_addr  = '0;
		t_wr_addr  = wr_idx_q[IDX_W-1:0];
		t_wr_width = rd_width;
		t_wr_mask  = mask_n;
		case (state_q)
			S_INIT: begin
				tctl.wr_en  = 1'b1;
				tctl.wr_cur = 1'b1;
				t_wr_addr   = '0;
				t_wr_width  = RESET_WIDTH;
				t_wr_mask   = {CHANNELS{1'b1}};
			end
			S_IDLE: begin
				tctl.rd_en = in_acc && upd;
			end
			S_MEVAL: begin
				if (hit) begin
					tctl.wr_en = 1'b1;
					t_wr_mask  = mask_n | bit_q;
				end else if (ins_here) begin
					tctl.wr_en = 1'b1;
					t_wr_width = w_q;
					t_wr_mask  = bit_q;
				end else begin
					tctl.wr_en = keep;
				end
				tctl.rd_en = !ins_here && more;
				t_rd_addr  = next_rd[IDX_W-1:0];
			end
			S_MWR2: begin
				tctl.wr_en = 1'b1;
				tctl.rd_en = more;
				t_rd_addr  = next_rd[IDX_W-1:0];
			end
			S_MTAIL: begin
				tctl.wr_en = !ins_q;
				tctl.swap  = 1'b1;
				t_wr_width = w_q;
				t_wr_mask  = bit_q;
			end
			S_ERD: begin
				tctl.rd_en = 1'b1;
				t_rd_addr  = k_q[IDX_W-1:0];
			end
			default: ;
		endcase
	end

	// sequencer and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_INIT;
			cnt_q          <= CNT_W'(1);
			rd_idx_q       <= '0;
			wr_idx_q       <= '0;
			k_q            <= '0;
			ins_q          <= 1'b0;
			w_q            <= '0;
			bit_q          <= '0;
			pattern_q      <= '0;
			out_valid_q    <= 1'b0;
			edge_index_q   <= '0;
			compare_time_q <= '0;
			pin_pattern_q  <= '0;
			last_q         <= 1'b0;
		end else begin
			// drop the word once taken, unless the emit step reloads it
			if (out_ready && (state_q != S_EOUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_acc) begin
						w_q       <= width;
						bit_q     <= in_bit;
						rd_idx_q  <= '0;
						wr_idx_q  <= '0;
						ins_q     <= 1'b0;
						k_q       <= '0;
						pattern_q <= {CHANNELS{1'b1}};
						state_q   <= upd ? S_MEVAL : S_ERD;
					end
				end
				S_MEVAL: begin
					if (hit || keep) begin
						wr_idx_q <= wr_idx_q + CNT_W'(1);
					end
					if (hit || ins_here) begin
						ins_q <= 1'b1;
					end
					if (ins_here) begin
						state_q <= S_MWR2;
					end else begin
						rd_idx_q <= next_rd;
						state_q  <= more ? S_MEVAL : S_MTAIL;
					end
				end
				S_MWR2: begin
					wr_idx_q <= wr_idx_q + CNT_W'(1);
					rd_idx_q <= next_rd;
					state_q  <= more ? S_MEVAL : S_MTAIL;
				end
				S_MTAIL: begin
					cnt_q     <= ins_q ? wr_idx_q : wr_idx_q + CNT_W'(1);
					k_q       <= '0;
					pattern_q <= {CHANNELS{1'b1}};
					state_q   <= S_ERD;
				end
				S_ERD: begin
					state_q <= S_EMUL;
				end
				S_EMUL: begin
					pattern_q <= pattern_q ^ rd_mask;
					state_q   <= S_EOUT;
				end
				S_EOUT: begin
					if (out_free) begin
						out_valid_q    <= 1'b1;
						edge_index_q   <= k_q[EIDX_W-1:0];
						compare_time_q <= cmp_time;
						pin_pattern_q  <= pattern_ext[PIN_W-1:0];
						last_q         <= is_last;
						k_q            <= k_q + CNT_W'(1);
						state_q        <= is_last ? S_IDLE : S_ERD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign edge_index   = edge_index_q;
	assign compare_time = compare_time_q;
	assign pin_pattern  = pin_pattern_q;
	assign last         = last_q;

	spe_table #(
		.CHANNELS (CHANNELS)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (tctl),
		.rd_addr  (t_rd_addr),
		.wr_addr  (t_wr_addr),
		.wr_width (t_wr_width),
		.wr_mask  (t_wr_mask),
		.rd_width (rd_width),
		.rd_mask  (rd_mask)
	);

	spe_compare u_compare (
		.clk              (clk),
		.en               (state_q == S_EMUL),
		.width            (rd_width),
		.ticks_per_us_q16 (tpu_q),
		.compare_delay    (delay_q),
		.compare_time     (cmp_time)
	);

	// the table never runs empty or past its depth
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) && (32'(cnt_q) <= CHANNELS))
		else $error("edge count out of range");

	// the rebuild write pointer stays at most one entry ahead of the read
	a_wr_behind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MEVAL || state_q == S_MWR2 || state_q == S_MTAIL) |->
		({1'b0, wr_idx_q} <= {1'b0, rd_idx_q} + {{CNT_W{1'b0}}, 1'b1}))
		else $error("rebuild write pointer overran read pointer");

	// an accepted item closes the input until its schedule is out
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("input accepted while busy");

	// a new word is loaded only by the emit step
	a_load_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EOUT))
		else $error("output word loaded outside emit step");

endmodule

[test/servo_pwm_edge_scheduler_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// servo_pwm_edge_scheduler_tb: self-checking bench for the servo edge table
// Sends channel width updates and predicts the full emitted schedule after
// each one: edge order, compare ticks after rate and delay, pin pattern and
// the closing flag. Runs several rate/delay settings, the extremes included,
// with random idling on both sides of the word handshakes.
// ----------------------------------------------------------------------------
module servo_pwm_edge_scheduler_tb;
	import spe_pkg::*;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int SETTLE       = 16;

	typedef struct {
		logic [EIDX_W-1:0] idx;
		logic [CMP_W-1:0]  cmp;
		logic [PIN_W-1:0]  pins;
		logic              fin;
	} edge_word_t;

	// Shadow edge table and the schedule words it is owed
	class edge_schedule_board;
		logic [WIDTH_W-1:0] widths[CHANNELS_DEF];
		logic [PIN_W-1:0]   masks[CHANNELS_DEF];
		int                 count;
		logic [DELAY_W-1:0] delay;
		logic [TPU_W-1:0]   rate;
		edge_word_t         pending[$];
		int                 errors;

		function new();
			foreach (widths[i]) begin
				widths[i] = '0;
				masks[i]  = '0;
			end
			widths[0] = RESET_WIDTH;
			masks[0]  = '1;
			count     = 1;
			delay     = DELAY_RST;
			rate      = TPU_RST;
			errors    = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
			case (idx)
			CFG_COMPARE_DELAY: delay = data[DELAY_W-1:0];
			CFG_TICKS_PER_US: rate = data[TPU_W-1:0];
			default: ;
			endcase
		endfunction

		// width times Q2.16 rate, minus delay, clamped to 16 bits
		function logic [CMP_W-1:0] ticks_at(logic [WIDTH_W-1:0] w);
			longint unsigned t;
			t = (64'(w) * 64'(rate)) >> FRAC_W;
			if (t <= 64'(delay))
				return '0;
			t -= 64'(delay);
			return (t > 64'd65535) ? '1 : CMP_W'(t);
		endfunction

		function void note_update(logic [CH_W-1:0] ch, logic [WIDTH_W-1:0] w);
			logic [PIN_W-1:0] ch_bit;
			logic [PIN_W-1:0] pins;
			edge_word_t       word;
			int               i;
			int               pos;
			ch_bit = PIN_W'(1) << ch;
			// drop the channel from its old edge, delete an emptied edge
			i = 0;
			while (i < count) begin
				masks[i] &= ~ch_bit;
				if (masks[i] == '0) begin
					for (int j = i; j + 1 < count; j++) begin
						masks[j]  = masks[j + 1];
						widths[j] = widths[j + 1];
					end
					count--;
				end else begin
					i++;
				end
			end
			// join an equal edge or open a new one in order
			pos = 0;
			while (pos < count && widths[pos] < w)
				pos++;
			if (pos < count && widths[pos] == w) begin
				masks[pos] |= ch_bit;
			end else if (count < CHANNELS_DEF) begin
				for (int j = count; j > pos; j--) begin
					widths[j] = widths[j - 1];
					masks[j]  = masks[j - 1];
				end
				widths[pos] = w;
				masks[pos]  = ch_bit;
				count++;
			end
			// queue the whole schedule
			pins = '1;
			for (int k = 0; k < count; k++) begin
				pins ^= masks[k];
				word.idx  = EIDX_W'(k);
				word.cmp  = ticks_at(widths[k]);
				word.pins = pins;
				word.fin  = (k + 1 == count);
				pending.push_back(word);
			end
		endfunction

		function void compare_field(string name, logic [PIN_W-1:0] want, logic [PIN_W-1:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_edge(logic [EIDX_W-1:0] idx, logic [CMP_W-1:0] cmp,
				logic [PIN_W-1:0] pins, logic fin);
			edge_word_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected edge word, expected none, actual index %0h",
					$time, idx);
				errors++;
				return;
			end
			want = pending.pop_front();
			compare_field("edge_index", PIN_W'(want.idx), PIN_W'(idx));
			compare_field("compare_time", PIN_W'(want.cmp), PIN_W'(cmp));
			compare_field("pin_pattern", want.pins, pins);
			compare_field("last", PIN_W'(want.fin), PIN_W'(fin));
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [CH_W-1:0]      channel;
	logic [WIDTH_W-1:0]   width;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [EIDX_W-1:0]    edge_index;
	logic [CMP_W-1:0]     compare_time;
	logic [PIN_W-1:0]     pin_pattern;
	logic                 last;

	edge_schedule_board board;
	int                 idle_pct = 20;
	int                 stall_left = 0;

	servo_pwm_edge_scheduler dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.channel      (channel),
		.width        (width),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.edge_index   (edge_index),
		.compare_time (compare_time),
		.pin_pattern  (pin_pattern),
		.last         (last)
	);

	always #4 clk = ~clk;

	// Check each accepted edge word, then stall the receiver in bursts
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_edge(edge_index, compare_time, pin_pattern, last);
		if (stall_left > 0)
			stall_left--;
		else if ($urandom_range(1, 100) <= idle_pct)
			stall_left = $urandom_range(1, 12);
		out_ready <= (stall_left == 0);
	end

	// Watchdog
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	// Send one width update, with an optional idle burst first
	task automatic push_update(input logic [CH_W-1:0] ch, input logic [WIDTH_W-1:0] w);
		if ($urandom_range(1, 100) <= idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		channel  <= ch;
		width    <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_update(ch, w);
	endtask

	// Hold the sender until every schedule word is back
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write both registers back to back; block must be idle
	task automatic program_rates(input logic [DELAY_W-1:0] d, input logic [TPU_W-1:0] r);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_COMPARE_DELAY;
		cfg_data  <= CFG_DAT_W'(d);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.set_register(CFG_COMPARE_DELAY, CFG_DAT_W'(d));
		cfg_index <= CFG_TICKS_PER_US;
		cfg_data  <= CFG_DAT_W'(r);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.set_register(CFG_TICKS_PER_US, CFG_DAT_W'(r));
		cfg_valid <= 1'b0;
	endtask

	// Half the time a small set of widths so channels share and vacate edges
	function automatic logic [WIDTH_W-1:0] pick_width();
		logic [WIDTH_W-1:0] common[6] = '{15'd0, 15'd1000, 15'd1500, 15'd1501, 15'd2000, 15'd32767};
		if ($urandom_range(0, 1) == 0)
			return common[$urandom_range(0, 5)];
		return WIDTH_W'($urandom_range(0, 32767));
	endfunction

	task automatic random_updates(input int n);
		repeat (n) push_update(CH_W'($urandom_range(0, 31)), pick_width());
	endtask

	initial begin
		board = new();
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		channel   <= '0;
		width     <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_COMPARE_DELAY;
		cfg_data  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, under reset rate and delay
		push_update(5'd0, 15'd1500);   // rejoin the same edge
		push_update(5'd0, 15'd0);      // new first edge, compare clamps to zero
		push_update(5'd31, 15'd32767); // new last edge
		push_update(5'd1, 15'd0);      // join an equal edge
		push_update(5'd0, 15'd1500);
		push_update(5'd1, 15'd1500);   // first edge empties and goes away
		push_update(5'd31, 15'd1500);  // back to a single edge
		push_update(5'd5, 15'd9);      // just under the delay
		push_update(5'd6, 15'd10);     // one tick above the delay
		push_update(5'd7, 15'h5555);
		push_update(5'd8, 15'h2AAA);
		push_update(5'd16, 15'd2000);
		push_update(5'd16, 15'd1000);  // own edge removed, new one inserted
		push_update(5'd15, 15'd1200);  // insert in the middle
		drain();

		// zero rate and delay
		program_rates(8'd0, 18'd0);
		random_updates(10);
		drain();

		// largest rate and delay, then one update for every channel
		program_rates(8'd255, 18'd262143);
		push_update(5'd2, 15'd32767);  // compare saturates high
		push_update(5'd3, 15'd63);     // just under the delay
		push_update(5'd4, 15'd64);     // exactly at the delay, compare still zero
		push_update(5'd9, 15'd1500);
		idle_pct = 10;
		for (int k = 0; k < 32; k++)
			push_update(CH_W'(k), WIDTH_W'($urandom_range(0, 32767)));
		drain();

		// random settings with heavy idling
		program_rates(DELAY_W'($urandom_range(0, 255)), TPU_W'($urandom_range(0, 262143)));
		idle_pct = 40;
		random_updates(30);
		drain();
		random_updates(30);
		drain();

		// unit rate, no idling on either side
		program_rates(8'd0, 18'd65536);
		idle_pct = 0;
		random_updates(10);
		drain();
		repeat (SETTLE) @(posedge clk);

		if (board.errors == 0 && board.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
